[hw/rtl/integer_to_spoken_word_tokens_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the spoken-word token generator.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_SPOKEN_WORD_TOKENS_DEFINES_SVH
`define INTEGER_TO_SPOKEN_WORD_TOKENS_DEFINES_SVH

// Same-cycle implication.
`define ITSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ITSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/itsw_pkg.sv]
// ----------------------------------------------------------------------------
// itsw_pkg
// Token codes, token and group types, and the small arithmetic helpers used
// by the spoken-word token generator.
// ----------------------------------------------------------------------------
`default_nettype none

package itsw_pkg;

	// Token kinds.
	localparam logic [3:0] TkNumber      = 4'd0;
	localparam logic [3:0] TkOneHundred  = 4'd1;
	localparam logic [3:0] TkHundred     = 4'd2;
	localparam logic [3:0] TkMinus       = 4'd3;
	localparam logic [3:0] TkOneBillion  = 4'd4;
	localparam logic [3:0] TkBillion     = 4'd5;
	localparam logic [3:0] TkOneMillion  = 4'd6;
	localparam logic [3:0] TkMillion     = 4'd7;
	localparam logic [3:0] TkOneThousand = 4'd8;
	localparam logic [3:0] TkThousand    = 4'd9;

	// Longest token run for one value.
	localparam int MaxTok = 14;
	// Number of segments: minus, billions, millions, thousands, units.
	localparam int NumSeg = 5;
	localparam int SegMinus = 0;
	localparam int SegBill  = 1;
	localparam int SegMill  = 2;
	localparam int SegThou  = 3;
	localparam int SegUnits = 4;

	// floor(x / 1000) = (x * Recip1000) >> RecipShift for any 32-bit x.
	localparam logic [31:0] Recip1000  = 32'd2199023256;
	localparam int          RecipShift = 41;

	// floor(g / 100) = (g * 41) >> 12 for g below 1000.
	localparam logic [5:0] Recip100 = 6'd41;

	typedef struct packed {
		logic [3:0] kind;
		logic [6:0] word;
	} tok_t;

	// One group of three digits, split into hundreds digit and remainder.
	typedef struct packed {
		logic [3:0] h;
		logic [6:0] r;
		logic       zero;
		logic       one;
	} grp_t;

	// Up to four tokens of one segment, packed from slot 0, with their count.
	typedef struct packed {
		tok_t [3:0] t;
		logic [2:0] cnt;
	} seg_t;

	function automatic tok_t mk_tok(logic [3:0] kind, logic [6:0] word);
		tok_t x;
		x.kind = kind;
		x.word = word;
		return x;
	endfunction

	// Split a group 0..999 into hundreds digit and remainder.
	function automatic grp_t split_grp(logic [9:0] g);
		grp_t       x;
		logic [15:0] prod;
		logic [10:0] hx;
		prod   = 16'(g) * 16'(Recip100);
		x.h    = prod[15:12];
		hx     = 11'(x.h) * 11'd100;
		x.r    = g[6:0] - hx[6:0];
		x.zero = (g == 10'd0);
		x.one  = (g == 10'd1);
		return x;
	endfunction

	// Token list of one group, with an optional scale word after it.
	function automatic seg_t seg_build(grp_t g, logic has_scale, logic [3:0] one_kind,
			logic [3:0] scale_kind);
		seg_t       s;
		logic [2:0] n;
		s = '0;
		n = 3'd0;
		if (has_scale && g.one) begin
			s.t[0] = mk_tok(one_kind, 7'd0);
			n = 3'd1;
		end else if (!g.zero) begin
			if (g.h == 4'd1) begin
				s.t[n[1:0]] = mk_tok(TkOneHundred, 7'd0);
				n = n + 3'd1;
			end else if (g.h != 4'd0) begin
				s.t[n[1:0]] = mk_tok(TkNumber, {3'd0, g.h});
				n = n + 3'd1;
				s.t[n[1:0]] = mk_tok(TkHundred, 7'd0);
				n = n + 3'd1;
			end
			if (g.r != 7'd0) begin
				s.t[n[1:0]] = mk_tok(TkNumber, g.r);
				n = n + 3'd1;
			end
			if (has_scale) begin
				s.t[n[1:0]] = mk_tok(scale_kind, 7'd0);
				n = n + 3'd1;
			end
		end
		s.cnt = n;
		return s;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/integer_to_spoken_word_tokens.sv]
// ----------------------------------------------------------------------------
// integer_to_spoken_word_tokens
// Turns a signed 32-bit value into the run of spoken-word tokens that reads
// it aloud, grouped by thousands, one token beat per cycle unless stalled.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   value
// out       output     out_valid / out_ready token_kind, number_word, last_token
//
// A value passes eight pipeline stages (magnitude, three reciprocal divides
// by 1000, digit split, segment build, run placement) and then a token
// shift buffer.
// The shift buffer sends one token per cycle while out_ready is high; a
// value has from 1 to 14 tokens, and a new value may enter every
// cycle while the pipeline has room.
// Reset clears every stage valid bit and the buffer count. A stall on the
// output holds the buffer and backs the pipeline up stage by stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_spoken_word_tokens_defines.svh"

module integer_to_spoken_word_tokens (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic signed [31:0] value,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [3:0]         token_kind,
	output      logic [6:0]         number_word,
	output      logic               last_token
);

	// Stage valid bits and ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;
	logic ser_take;

	// Stage payloads.
	logic        neg_s1, zero_s1;
	logic [31:0] mag_s1;
	logic        neg_s2, zero_s2;
	logic [31:0] mag_s2;
	logic [21:0] q1_s2;
	logic        neg_s3, zero_s3;
	logic [9:0]  units_s3;
	logic [21:0] q1_s3;
	logic [11:0] q2_s3;
	logic        neg_s4, zero_s4;
	logic [9:0]  units_s4, thou_s4;
	logic [11:0] q2_s4;
	logic [1:0]  q3_s4;
	logic        neg_s5, zero_s5;
	logic [9:0]  units_s5, thou_s5, mill_s5;
	logic [1:0]  bill_s5;
	logic        neg_s6, zero_s6;
	itsw_pkg::grp_t bill_g_s6, mill_g_s6, thou_g_s6, units_g_s6;
	itsw_pkg::seg_t seg_s7 [itsw_pkg::NumSeg];
	itsw_pkg::tok_t tok_s8 [itsw_pkg::MaxTok];
	logic [3:0]  cnt_s8;

	// Output shift buffer.
	itsw_pkg::tok_t ser_tok_q [itsw_pkg::MaxTok];
	logic [3:0]     ser_cnt_q;

	// Combinational stage results.
	logic [31:0] raw_d, mag_d;
	logic [63:0] prod1_d;
	logic [53:0] prod2_d;
	logic [43:0] prod3_d;
	logic [31:0] q1k_d;
	logic [21:0] q2k_d;
	logic [11:0] q3k_d;
	itsw_pkg::seg_t seg_d [itsw_pkg::NumSeg];
	itsw_pkg::tok_t tok_d [itsw_pkg::MaxTok];
	logic [3:0]  offs_d [itsw_pkg::NumSeg];
	logic [3:0]  total_d;

	// Conditions watched by the checks.
	logic grp_ok;
	logic run_ok;
	logic last_drain;

	// The buffer takes a new run when empty or when its last beat leaves.
	assign ser_take = (ser_cnt_q == 4'd0) || (out_ready && ser_cnt_q == 4'd1);
	assign rdy_s8 = !v_s8 || ser_take;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Valid bits move forward wherever the next stage has room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// Magnitude, reciprocal products and remainders of the divide stages.
	always_comb begin
		raw_d   = unsigned'(value);
		mag_d   = raw_d[31] ? (32'd0 - raw_d) : raw_d;
		prod1_d = 64'(mag_s1) * 64'(itsw_pkg::Recip1000);
		prod2_d = 54'(q1_s2) * 54'(itsw_pkg::Recip1000);
		prod3_d = 44'(q2_s3) * 44'(itsw_pkg::Recip1000);
		q1k_d   = 32'(q1_s2) * 32'd1000;
		q2k_d   = 22'(q2_s3) * 22'd1000;
		q3k_d   = 12'(q3_s4) * 12'd1000;
	end

	// Stages one to six: magnitude, three divides by 1000, digit split.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			neg_s1  <= raw_d[31];
			zero_s1 <= (raw_d == 32'd0);
			mag_s1  <= mag_d;
		end
		if (rdy_s2 && v_s1) begin
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			mag_s2  <= mag_s1;
			q1_s2   <= prod1_d[62:41];
		end
		if (rdy_s3 && v_s2) begin
			neg_s3   <= neg_s2;
			zero_s3  <= zero_s2;
			units_s3 <= mag_s2[9:0] - q1k_d[9:0];
			q1_s3    <= q1_s2;
			q2_s3    <= prod2_d[52:41];
		end
		if (rdy_s4 && v_s3) begin
			neg_s4   <= neg_s3;
			zero_s4  <= zero_s3;
			units_s4 <= units_s3;
			thou_s4  <= q1_s3[9:0] - q2k_d[9:0];
			q2_s4    <= q2_s3;
			q3_s4    <= prod3_d[42:41];
		end
		if (rdy_s5 && v_s4) begin
			neg_s5   <= neg_s4;
			zero_s5  <= zero_s4;
			units_s5 <= units_s4;
			thou_s5  <= thou_s4;
			mill_s5  <= q2_s4[9:0] - q3k_d[9:0];
			bill_s5  <= q3_s4;
		end
		if (rdy_s6 && v_s5) begin
			neg_s6     <= neg_s5;
			zero_s6    <= zero_s5;
			bill_g_s6  <= itsw_pkg::split_grp({8'd0, bill_s5});
			mill_g_s6  <= itsw_pkg::split_grp(mill_s5);
			thou_g_s6  <= itsw_pkg::split_grp(thou_s5);
			units_g_s6 <= itsw_pkg::split_grp(units_s5);
		end
	end

	// Token lists of each segment; a zero value speaks a lone number word.
	always_comb begin
		seg_d[itsw_pkg::SegMinus] = '0;
		seg_d[itsw_pkg::SegMinus].t[0] = itsw_pkg::mk_tok(itsw_pkg::TkMinus, 7'd0);
		seg_d[itsw_pkg::SegMinus].cnt = {2'd0, neg_s6};
		seg_d[itsw_pkg::SegBill] = itsw_pkg::seg_build(bill_g_s6, 1'b1,
			itsw_pkg::TkOneBillion, itsw_pkg::TkBillion);
		seg_d[itsw_pkg::SegMill] = itsw_pkg::seg_build(mill_g_s6, 1'b1,
			itsw_pkg::TkOneMillion, itsw_pkg::TkMillion);
		seg_d[itsw_pkg::SegThou] = itsw_pkg::seg_build(thou_g_s6, 1'b1,
			itsw_pkg::TkOneThousand, itsw_pkg::TkThousand);
		seg_d[itsw_pkg::SegUnits] = itsw_pkg::seg_build(units_g_s6, 1'b0,
			itsw_pkg::TkNumber, itsw_pkg::TkNumber);
		if (zero_s6) begin
			seg_d[itsw_pkg::SegUnits] = '0;
			seg_d[itsw_pkg::SegUnits].t[0] = itsw_pkg::mk_tok(itsw_pkg::TkNumber, 7'd0);
			seg_d[itsw_pkg::SegUnits].cnt = 3'd1;
		end
	end

	// Place the segments one after another into a single run.
	always_comb begin
		logic [3:0] jj;
		logic [3:0] rel;
		logic [3:0] segc;
		offs_d[0] = 4'd0;
		for (int s = 1; s < itsw_pkg::NumSeg; s++) begin
			offs_d[s] = offs_d[s-1] + {1'b0, seg_s7[s-1].cnt};
		end
		total_d = offs_d[itsw_pkg::NumSeg-1] + {1'b0, seg_s7[itsw_pkg::NumSeg-1].cnt};
		for (int j = 0; j < itsw_pkg::MaxTok; j++) begin
			jj = 4'(j);
			tok_d[j] = '0;
			for (int s = 0; s < itsw_pkg::NumSeg; s++) begin
				segc = {1'b0, seg_s7[s].cnt};
				rel  = jj - offs_d[s];
				if (jj >= offs_d[s] && jj < offs_d[s] + segc) begin
					tok_d[j] = seg_s7[s].t[rel[1:0]];
				end
			end
		end
	end

	// Stages seven and eight: segment lists, then the placed run.
	always_ff @(posedge clk) begin
		if (rdy_s7 && v_s6) begin
			for (int s = 0; s < itsw_pkg::NumSeg; s++) begin
				seg_s7[s] <= seg_d[s];
			end
		end
		if (rdy_s8 && v_s7) begin
			for (int j = 0; j < itsw_pkg::MaxTok; j++) begin
				tok_s8[j] <= tok_d[j];
			end
			cnt_s8 <= total_d;
		end
	end

	// Buffer count: load a run, or drop one token per delivered beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_cnt_q <= 4'd0;
		end else if (ser_take && v_s8) begin
			ser_cnt_q <= cnt_s8;
		end else if (out_valid && out_ready) begin
			ser_cnt_q <= ser_cnt_q - 4'd1;
		end
	end

	// Buffer tokens: the head always sits in slot zero.
	always_ff @(posedge clk) begin
		if (ser_take && v_s8) begin
			for (int j = 0; j < itsw_pkg::MaxTok; j++) begin
				ser_tok_q[j] <= tok_s8[j];
			end
		end else if (out_valid && out_ready) begin
			for (int j = 0; j < itsw_pkg::MaxTok - 1; j++) begin
				ser_tok_q[j] <= ser_tok_q[j+1];
			end
		end
	end

	assign out_valid   = (ser_cnt_q != 4'd0);
	assign token_kind  = ser_tok_q[0].kind;
	assign number_word = ser_tok_q[0].word;
	assign last_token  = (ser_cnt_q == 4'd1);

	// Groups after the divides, run length, and a final beat with nothing behind it.
	assign grp_ok = (units_s5 < 10'd1000) && (thou_s5 < 10'd1000) &&
		(mill_s5 < 10'd1000) && (bill_s5 <= 2'd2);
	assign run_ok = (cnt_s8 != 4'd0) && (cnt_s8 <= 4'd14);
	assign last_drain = out_valid && out_ready && last_token && !v_s8;

	// Checks on the divide chain, the run length and the buffer drain.
	`ITSW_ASSERT_NOW(a_groups_in_range, clk, arst_n, v_s5, grp_ok, "group out of range")
	`ITSW_ASSERT_NOW(a_run_length, clk, arst_n, v_s8, run_ok, "run length out of range")
	`ITSW_ASSERT_NEXT(a_drain_empty, clk, arst_n, last_drain, !out_valid, "buffer not empty")

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for integer_to_spoken_word_tokens
// Sends signed 32-bit values through the input channel and checks every token
// beat against a predictor that spells each accepted value by thousands
// groups. Both channels idle and stall at random, and the sender drains the
// block completely at three points in the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int RunLimit = 600000;

	// One expected token beat.
	typedef struct packed {
		logic [3:0] kind;
		logic [6:0] word;
		logic       last;
	} spoken_tok_t;

	// One entry of the stimulus list: a value, or a request to drain the block.
	typedef struct {
		logic        drain;
		logic [31:0] val;
		int          pause;
	} value_req_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [3:0]         token_kind;
	logic [6:0]         number_word;
	logic               last_token;

	value_req_t  pending[$];
	spoken_tok_t tokens_due[$];
	spoken_tok_t spelled[$];
	value_req_t  nxt;
	int          mismatches = 0;
	int          cycle_cnt = 0;
	int          tx_hold = 0;
	logic        tx_waited = 1'b0;
	int          rx_stall = 0;
	int          rx_mode = 1;

	integer_to_spoken_word_tokens dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.number_word(number_word),
		.last_token(last_token)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Global cycle limit in case the block hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RunLimit) begin
			$display("[integer_to_spoken_word_tokens] ERROR");
			$finish;
		end
	end

	// Mode 0 never idles; modes 1 and 2 mix short and occasional long gaps.
	function automatic int pick_pause(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0)
			return 0;
		if (r < ((mode == 1) ? 65 : 35))
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Append one token to the run being spelled.
	task automatic say(logic [3:0] kind, logic [6:0] word);
		spelled.push_back('{kind, word, 1'b0});
	endtask

	// Speak a group of 0..999 as its hundreds part and remainder.
	task automatic say_hundreds(int unsigned grp);
		int unsigned hd;
		int unsigned rem;
		hd = grp / 100;
		rem = grp % 100;
		if (hd == 1)
			say(itsw_pkg::TkOneHundred, 7'd0);
		else if (hd > 1) begin
			say(itsw_pkg::TkNumber, 7'(hd));
			say(itsw_pkg::TkHundred, 7'd0);
		end
		if (rem > 0)
			say(itsw_pkg::TkNumber, 7'(rem));
	endtask

	// Speak a scaled group; a group of exactly one has its own token.
	task automatic say_scaled(int unsigned grp, logic [3:0] one_kind, logic [3:0] scale_kind);
		if (grp == 1)
			say(one_kind, 7'd0);
		else if (grp != 0) begin
			say_hundreds(grp);
			say(scale_kind, 7'd0);
		end
	endtask

	// Spell one accepted value and queue its tokens, marking the final one.
	task automatic predict_tokens(logic [31:0] v);
		logic [31:0] mag;
		spoken_tok_t t;
		spelled.delete();
		// Negating the most negative value wraps to 2^31, which is its magnitude.
		mag = v[31] ? (32'd0 - v) : v;
		if (mag == 32'd0)
			say(itsw_pkg::TkNumber, 7'd0);
		else begin
			if (v[31])
				say(itsw_pkg::TkMinus, 7'd0);
			say_scaled(mag / 1000000000, itsw_pkg::TkOneBillion, itsw_pkg::TkBillion);
			say_scaled((mag / 1000000) % 1000, itsw_pkg::TkOneMillion, itsw_pkg::TkMillion);
			say_scaled((mag / 1000) % 1000, itsw_pkg::TkOneThousand, itsw_pkg::TkThousand);
			say_hundreds(mag % 1000);
		end
		for (int i = 0; i < spelled.size(); i++) begin
			t = spelled[i];
			t.last = (i == spelled.size() - 1);
			tokens_due.push_back(t);
		end
	endtask

	// Compare one output beat with the oldest expected token.
	task automatic check_token();
		spoken_tok_t want;
		spoken_tok_t seen;
		seen = '{token_kind, number_word, last_token};
		if (tokens_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected token beat: kind %0d word %0d last %0b",
					seen.kind, seen.word, seen.last);
		end else begin
			want = tokens_due.pop_front();
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("token mismatch: expected kind %0d word %0d last %0b,",
						want.kind, want.word, want.last,
						" got kind %0d word %0d last %0b",
						seen.kind, seen.word, seen.last);
			end
		end
	endtask

	// Driver: presents values from the pending list and predicts each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			tx_hold = 0;
			tx_waited = 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predict_tokens(value);
			if (tx_hold > 0) begin
				tx_hold--;
				in_valid <= 1'b0;
			end else if (pending.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending[0].drain) begin
				// Hold off until every token already owed has come out.
				in_valid <= 1'b0;
				if (tokens_due.size() == 0)
					void'(pending.pop_front());
			end else if (!tx_waited && pending[0].pause > 0) begin
				tx_hold = pending[0].pause - 1;
				tx_waited = 1'b1;
				in_valid <= 1'b0;
			end else begin
				nxt = pending.pop_front();
				tx_waited = 1'b0;
				in_valid <= 1'b1;
				value <= nxt.val;
			end
		end
	end

	// Monitor: checks token beats and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (out_valid && out_ready)
				check_token();
			if ($urandom_range(0, 127) == 0)
				rx_mode = $urandom_range(0, 2);
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_stall = pick_pause(rx_mode);
			end
		end
	end

	// Random group value biased toward zero, one and round hundreds.
	function automatic int unsigned pick_group();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 1;
			2: return $urandom_range(100, 199);
			3: return $urandom_range(2, 9) * 100;
			4: return $urandom_range(1, 99);
			default: return $urandom_range(0, 999);
		endcase
	endfunction

	task automatic add_value(logic [31:0] v, int mode);
		pending.push_back('{1'b0, v, pick_pause(mode)});
	endtask

	task automatic add_drain();
		pending.push_back('{1'b1, 32'd0, 0});
	endtask

	initial begin
		logic [63:0] mag;
		logic [31:0] v;
		int          tx_mode;

		// Directed values: extremes, every token kind and the group edge cases.
		add_value(32'd0, 0);
		add_value(32'd1, 0);
		add_value(-32'sd1, 0);
		add_value(32'h7FFF_FFFF, 0);
		add_value(32'h8000_0000, 0);
		add_value(32'd100, 0);
		add_value(32'd101, 0);
		add_value(32'd199, 0);
		add_value(32'd200, 0);
		add_value(32'd999, 0);
		add_value(32'd1000, 0);
		add_value(32'd1001, 0);
		add_value(32'd1100, 0);
		add_value(32'd1000000, 0);
		add_value(32'd1000001, 0);
		add_value(32'd1000000000, 0);
		add_value(32'd1001001001, 0);
		add_value(32'd2000000000, 0);
		add_value(32'd911911911, 0);
		add_value(32'd100100100, 0);
		add_value(32'd123456789, 0);
		add_value(-32'sd1000, 0);
		add_value(-32'sd999999999, 0);
		add_value(32'h5555_5555, 0);
		add_value(32'hAAAA_AAAA, 0);
		add_drain();

		// Random values: mostly composed from chosen groups, some raw bit patterns.
		tx_mode = 1;
		for (int i = 0; i < 420; i++) begin
			if (i % 30 == 0)
				tx_mode = $urandom_range(0, 2);
			if (i == 140 || i == 280)
				add_drain();
			if ($urandom_range(0, 9) < 3)
				v = $urandom;
			else begin
				mag = 64'($urandom_range(0, 2)) * 64'd1000000000 +
					64'(pick_group()) * 64'd1000000 +
					64'(pick_group()) * 64'd1000 + 64'(pick_group());
				if (mag > 64'd2147483648)
					mag = mag % 64'd2147483649;
				v = $urandom_range(0, 1) ? (32'd0 - mag[31:0]) : mag[31:0];
			end
			add_value(v, tx_mode);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("[integer_to_spoken_word_tokens] OK");
		else
			$display("[integer_to_spoken_word_tokens] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
